/* rtl/sine_tone_generator_core_macros.svh */
// Assertion helpers shared by the sine tone generator RTL.
// They expect clk and rst_n in the scope where they are used.
`ifndef SINE_TONE_GENERATOR_CORE_MACROS_SVH
`define SINE_TONE_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication
`define STG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define STG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/stg_pkg.sv */
package stg_pkg;

    // Channel count of the tone source; mask bits above it are never active
    localparam int CHANNELS = 8;
    localparam logic [7:0] CHANNEL_MASK = (CHANNELS >= 8) ? 8'hFF : 8'((1 << CHANNELS) - 1);

    // Seek multiply: low 32 position bits, one byte per cell
    localparam int CELL_BITS = 8;
    localparam int NUM_CELLS = 32 / CELL_BITS;

    // Command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_SEEK   = 1'b1;

    // Register word index
    localparam logic REG_PHASE_INC = 1'b0;

    // Quarter-wave table generation constants (Q2.30)
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int FRAC_BITS    = 30;
    localparam int FULL_SCALE   = 32767;
    localparam int SERIES_TERMS = 14;

    typedef struct packed {
        logic        command;
        logic [7:0]  silent_mask;
        logic [47:0] seek_position;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] sample_value;
        logic [7:0]         active_channels;
    } smp_t;

    // Item payload carried along the cell chain
    typedef struct packed {
        logic        seek;
        logic [7:0]  active;
        logic [31:0] offset;
        logic [31:0] pos;
        logic [31:0] mul;
        logic [31:0] acc;
    } cell_t;

    // Lookup flags after phase decode
    typedef struct packed {
        logic       top;
        logic       neg;
        logic [7:0] active;
    } look_t;

    // Taylor term divisor (2n)(2n+1)
    function automatic longint unsigned series_div(input int n, input longint unsigned v);
        case (n)
            1:       return v / 6;
            2:       return v / 20;
            3:       return v / 42;
            4:       return v / 72;
            5:       return v / 110;
            6:       return v / 156;
            7:       return v / 210;
            8:       return v / 272;
            9:       return v / 342;
            10:      return v / 420;
            11:      return v / 506;
            12:      return v / 600;
            13:      return v / 702;
            14:      return v / 812;
            default: return v;
        endcase
    endfunction

    // Quarter-wave entry k of 2^(tab_bits-2), evaluated at elaboration only
    function automatic logic [14:0] quarter_entry(input int tab_bits, input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned scaled;
        x = (HALF_PI_Q30 * 64'(k) + (64'd1 << (tab_bits - 3))) >> (tab_bits - 2);
        x2 = (x * x) >> FRAC_BITS;
        term = x;
        sum = x;
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            term = series_div(n, (term * x2) >> FRAC_BITS);
            if ((n & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        scaled = (sum * 64'(FULL_SCALE) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (scaled > 64'(FULL_SCALE))
            scaled = 64'(FULL_SCALE);
        return 15'(scaled);
    endfunction

endpackage

/* rtl/stg_cell.sv */
// One byte step of the seek multiply; samples just pass through
module stg_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_in,
    input  stg_pkg::cell_t data_in,
    output logic          valid_out,
    output stg_pkg::cell_t data_out
);

    logic           valid_reg;
    stg_pkg::cell_t data_reg;
    stg_pkg::cell_t data_next;
    logic [39:0]    prod;

    // Partial product of the low position byte, then shift to the next byte
    always_comb
    begin
        prod = 40'(data_in.pos[stg_pkg::CELL_BITS-1:0]) * 40'(data_in.mul);
        data_next = data_in;
        data_next.acc = data_in.acc + prod[31:0];
        data_next.mul = data_in.mul << stg_pkg::CELL_BITS;
        data_next.pos = data_in.pos >> stg_pkg::CELL_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

/* rtl/stg_phase.sv */
// Absolute phase from seek base plus offset, decoded to a quarter-table address
module stg_phase #(
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_in,
    input  stg_pkg::cell_t             data_in,
    output logic                       valid_out,
    output logic [TABLE_ADDR_BITS-3:0] addr,
    output stg_pkg::look_t             look
);

    localparam int AW = TABLE_ADDR_BITS - 2;

    logic [31:0]              base_reg;
    logic [31:0]              phase;
    logic [TABLE_ADDR_BITS-1:0] idx;
    logic [1:0]               quad;
    logic [AW-1:0]            qoff;
    logic                     valid_reg;
    logic                     valid_next;
    logic [AW-1:0]            addr_reg;
    logic [AW-1:0]            addr_next;
    stg_pkg::look_t           look_reg;
    stg_pkg::look_t           look_next;

    // Phase decode: quadrant mirrors and negates the quarter table
    always_comb
    begin
        phase = base_reg + data_in.offset;
        idx = phase[31 -: TABLE_ADDR_BITS];
        quad = idx[TABLE_ADDR_BITS-1 -: 2];
        qoff = idx[AW-1:0];
        addr_next = quad[0] ? AW'(~qoff + 1'b1) : qoff;
        look_next.top = quad[0] && (qoff == '0);
        look_next.neg = quad[1];
        look_next.active = data_in.active;
        valid_next = valid_in && !data_in.seek;
    end

    // Seek product becomes the new base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
            if (valid_in && data_in.seek)
                base_reg <= data_in.acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            addr_reg <= addr_next;
            look_reg <= look_next;
        end
    end

    assign valid_out = valid_reg;
    assign addr      = addr_reg;
    assign look      = look_reg;

endmodule

/* rtl/stg_rom.sv */
// Quarter-wave table with registered read
module stg_rom #(
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_in,
    input  logic [TABLE_ADDR_BITS-3:0] addr,
    input  stg_pkg::look_t             look_in,
    output logic                       valid_out,
    output logic [14:0]                raw,
    output stg_pkg::look_t             look_out
);

    localparam int QLEN = 1 << (TABLE_ADDR_BITS - 2);
    localparam logic [14:0] TOP_VALUE = stg_pkg::quarter_entry(TABLE_ADDR_BITS, QLEN);

    logic [14:0]    tab [QLEN];
    logic           valid_reg;
    logic [14:0]    raw_reg;
    stg_pkg::look_t look_reg;

    // Constant entries computed at elaboration
    for (genvar k = 0; k < QLEN; k++)
    begin : g_tab
        localparam logic [14:0] ENTRY = stg_pkg::quarter_entry(TABLE_ADDR_BITS, k);
        assign tab[k] = ENTRY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    // Quarter point itself lies one past the table
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg  <= look_in.top ? TOP_VALUE : tab[addr];
            look_reg <= look_in;
        end
    end

    assign valid_out = valid_reg;
    assign raw       = raw_reg;
    assign look_out  = look_reg;

endmodule

/* rtl/sine_tone_generator_core.sv */
// Pipeline: a command passes 4 multiply cells, then the phase, table and out registers, before smp_valid rises.
// Throughput: one item per cycle while cmd_stall is low; the seek multiply runs byte by byte down a chain of 4 cells.
// A seek gives no result; the phase a sample sees is tracked as seek base plus running offset.
// cmd_stall rises only while the output skid register is full under a stalled consumer.
// Reset (async, active low): phase increment, phase and offset cleared, pipeline emptied.
`include "sine_tone_generator_core_macros.svh"

module sine_tone_generator_core #(
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    // APB configuration
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    // command channel
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  stg_pkg::cmd_t  cmd_data,
    // sample channel
    output logic           smp_valid,
    input  logic           smp_stall,
    output stg_pkg::smp_t  smp_data
);

    localparam int AW = TABLE_ADDR_BITS - 2;

    logic [31:0]    inc_reg;
    logic [31:0]    offset_reg;
    logic [31:0]    offset_next;
    logic           en;
    logic           accept;
    logic           cfg_write;

    logic           cell_valid [stg_pkg::NUM_CELLS+1];
    stg_pkg::cell_t cell_data  [stg_pkg::NUM_CELLS+1];

    logic           ph_valid;
    logic [AW-1:0]  ph_addr;
    stg_pkg::look_t ph_look;

    logic           rom_valid;
    logic [14:0]    rom_raw;
    stg_pkg::look_t rom_look;

    stg_pkg::smp_t  pipe_item;
    logic           out_valid_reg;
    logic           out_valid_next;
    stg_pkg::smp_t  out_data_reg;
    stg_pkg::smp_t  out_data_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    stg_pkg::smp_t  skid_data_reg;
    stg_pkg::smp_t  skid_data_next;
    logic           out_take;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == stg_pkg::REG_PHASE_INC) ? inc_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inc_reg <= '0;
        else if (cfg_write && (paddr[2] == stg_pkg::REG_PHASE_INC))
            inc_reg <= pwdata;
    end

    // Whole pipeline moves unless the skid register holds a result
    assign en        = !skid_valid_reg;
    assign cmd_stall = skid_valid_reg;
    assign accept    = cmd_valid && !cmd_stall;

    // Offset since last seek; a seek restarts it
    always_comb
    begin
        offset_next = offset_reg;
        if (accept)
        begin
            if (cmd_data.command == stg_pkg::CMD_SEEK)
                offset_next = '0;
            else
                offset_next = offset_reg + inc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else
            offset_reg <= offset_next;
    end

    // Entry of the cell chain
    always_comb
    begin
        cell_valid[0] = accept;
        cell_data[0].seek   = (cmd_data.command == stg_pkg::CMD_SEEK);
        cell_data[0].active = ~cmd_data.silent_mask & stg_pkg::CHANNEL_MASK;
        cell_data[0].offset = offset_reg;
        cell_data[0].pos    = cmd_data.seek_position[31:0];
        cell_data[0].mul    = inc_reg;
        cell_data[0].acc    = '0;
    end

    for (genvar i = 0; i < stg_pkg::NUM_CELLS; i++)
    begin : g_cell
        stg_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (cell_valid[i]),
            .data_in   (cell_data[i]),
            .valid_out (cell_valid[i+1]),
            .data_out  (cell_data[i+1])
        );
    end

    stg_phase #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (cell_valid[stg_pkg::NUM_CELLS]),
        .data_in   (cell_data[stg_pkg::NUM_CELLS]),
        .valid_out (ph_valid),
        .addr      (ph_addr),
        .look      (ph_look)
    );

    stg_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (ph_valid),
        .addr      (ph_addr),
        .look_in   (ph_look),
        .valid_out (rom_valid),
        .raw       (rom_raw),
        .look_out  (rom_look)
    );

    // Sign and silence
    always_comb
    begin
        pipe_item.active_channels = rom_look.active;
        if (rom_look.active == '0)
            pipe_item.sample_value = '0;
        else if (rom_look.neg)
            pipe_item.sample_value = 16'(-$signed({1'b0, rom_raw}));
        else
            pipe_item.sample_value = $signed({1'b0, rom_raw});
    end

    // Output register with skid
    assign out_take = out_valid_reg && !smp_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (rom_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = pipe_item;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = pipe_item;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign smp_valid = out_valid_reg;
    assign smp_data  = out_data_reg;

    // Checks
    `STG_ASSERT_NOW(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `STG_ASSERT_NEXT(a_skid_fill_cause, !skid_valid_reg && !(out_valid_reg && smp_stall), !skid_valid_reg, "skid filled without a stalled output")
    `STG_ASSERT_NEXT(a_skid_drain, skid_valid_reg && !smp_stall, out_valid_reg && !skid_valid_reg, "skid did not drain into output")

endmodule
